// ----- src/assert_macros.svh -----
// Assertion macros used by the RTL of the sprite DMA block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("sprite DMA assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("sprite DMA assertion failed");

`endif

// ----- src/sdma_pkg.sv -----
// Package with the word types and constants of the sprite DMA block.
`default_nettype none

package sdma_pkg;

    localparam logic [7:0] OPEN_BUS_BYTE = 8'hFF;
    localparam logic [7:0] PAGE_BOUNDARY = 8'h00;

    typedef struct packed {
        logic       cpu_halted;
        logic       audio_dma_fetch;
        logic       get_phase;
        logic [7:0] read_data;
        logic       read_ok;
        logic       start_req;
        logic [7:0] start_page;
    } t_in_word;

    typedef struct packed {
        logic        ready_hold;
        logic        did_transfer;
        logic        read_strobe;
        logic        write_strobe;
        logic [7:0]  write_byte;
        logic [15:0] fetch_address;
    } t_out_word;

endpackage

`default_nettype wire

// ----- src/sdma_if.sv -----
// Valid/ready channel interfaces for the input and result words of the sprite DMA block.
`default_nettype none

interface sdma_in_if
    import sdma_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sdma_out_if
    import sdma_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/sprite_memory_dma_controller.sv -----
// Sprite-memory DMA engine: one input word per machine cycle, one result word back.
`default_nettype none
`include "assert_macros.svh"

// Each input word describes one machine cycle and yields exactly one result word.
// The block takes one word per clock unless the output register is held: the engine
// state advances in the cycle the word is accepted, and the result sits in a single
// output register. The input stays ready whenever that register is empty or being
// emptied in the same cycle, so with the output side always ready the sustained rate
// is one word per clock. No word is taken while reset is asserted. A start request
// takes effect on the following word; fetch_address tells the system which byte the
// next word's read_data must carry.
module sprite_memory_dma_controller
    import sdma_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sdma_in_if.sink          i_in,
    sdma_out_if.source       o_out
);

    // Engine state
    logic        r_start_pending, n_start_pending;
    logic [7:0]  r_pending_page,  n_pending_page;
    logic        r_active,        n_active;
    logic [15:0] r_src_addr,      n_src_addr;
    logic        r_byte_held,     n_byte_held;
    logic [7:0]  r_latched_byte,  n_latched_byte;

    // Result register
    logic        r_out_valid;
    t_out_word   r_out_data, n_out_data;

    logic        in_ready;
    logic        in_accept;
    logic        act_now;
    logic [15:0] addr_now;
    logic        held_now;

    logic        rd_taken;
    logic        wr_taken;
    logic        run_stopped;

    assign in_ready    = i_rst_n && (!r_out_valid || o_out.ready);
    assign in_accept   = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // A pending start is applied before this cycle's step.
    assign act_now  = r_start_pending || r_active;
    assign addr_now = r_start_pending ? {r_pending_page, 8'h00} : r_src_addr;
    assign held_now = r_start_pending ? 1'b0 : r_byte_held;

    always_comb begin
        n_active       = act_now;
        n_src_addr     = addr_now;
        n_byte_held    = held_now;
        n_latched_byte = r_latched_byte;
        n_out_data     = '0;
        n_out_data.ready_hold = act_now;

        if (act_now && i_in.data.cpu_halted) begin
            if (i_in.data.get_phase) begin
                if (!i_in.data.audio_dma_fetch) begin
                    n_latched_byte = i_in.data.read_ok ? i_in.data.read_data : OPEN_BUS_BYTE;
                    n_byte_held    = 1'b1;
                    n_src_addr     = addr_now + 16'd1;
                    n_out_data.read_strobe = 1'b1;
                end
            end else if (held_now) begin
                n_out_data.write_strobe = 1'b1;
                n_out_data.write_byte   = r_latched_byte;
                n_byte_held             = 1'b0;
                // The write that leaves the address on a page boundary ends the transfer.
                if (addr_now[7:0] == PAGE_BOUNDARY) begin
                    n_active = 1'b0;
                end
            end
        end

        n_out_data.did_transfer = n_out_data.read_strobe || n_out_data.write_strobe;

        // A start request here replaces any earlier one; the pending one was consumed above.
        n_start_pending = i_in.data.start_req;
        n_pending_page  = i_in.data.start_req ? i_in.data.start_page : r_pending_page;

        n_out_data.fetch_address = i_in.data.start_req ? {i_in.data.start_page, 8'h00}
                                                       : n_src_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pending <= 1'b0;
            r_pending_page  <= '0;
            r_active        <= 1'b0;
            r_src_addr      <= '0;
            r_byte_held     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_accept) begin
                r_start_pending <= n_start_pending;
                r_pending_page  <= n_pending_page;
                r_active        <= n_active;
                r_src_addr      <= n_src_addr;
                r_byte_held     <= n_byte_held;
                r_out_valid     <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    // The latched byte is only read while the held flag is set, so it needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_latched_byte <= n_latched_byte;
            r_out_data     <= n_out_data;
        end
    end

    assign rd_taken    = in_accept && n_out_data.read_strobe;
    assign wr_taken    = in_accept && n_out_data.write_strobe;
    assign run_stopped = in_accept && r_active && !r_start_pending && !n_active;

    // A sprite write always consumes a byte that was held before the step.
    `ASSERT_CLKD(a_write_needs_held, i_clk, i_rst_n, wr_taken |-> r_byte_held)
    // A latched read leaves a byte held for the next put cycle.
    `ASSERT_CLKD(a_read_sets_held, i_clk, i_rst_n, rd_taken |=> r_byte_held)
    // A running transfer without a restart stops only through a sprite write.
    `ASSERT_CLKD(a_stop_on_write, i_clk, i_rst_n, run_stopped |-> wr_taken)
    // An untaken result word stays in the output register.
    `ASSERT_CLKD(a_result_held, i_clk, i_rst_n, (r_out_valid && !o_out.ready) |=> r_out_valid)

endmodule

`default_nettype wire
